@@ design/dbc_pkg.sv @@
// dbc_pkg: shared types and constants of the destination bypass classifier
// holds request payload structs, prefix table row, reason and register codes
// no dependencies
`default_nettype none

package dbc_pkg;

  // classification and table-write request
  typedef struct packed {
    logic        action;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] dest_port;
    logic [5:0]  entry_index;
    logic [7:0]  entry_length;
    logic        entry_valid;
  } in_item_t;

  // result request
  typedef struct packed {
    logic        bypass;
    logic        set_mark;
    logic [31:0] mark_out;
    logic [2:0]  reason;
  } out_item_t;

  // one prefix table row
  typedef struct packed {
    logic         valid;
    logic         is_v6;
    logic [7:0]   len;
    logic [127:0] bits;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic eval;
    logic clr_step;
    logic scan_step;
    logic mem_write;
    logic push_result;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic item_is_write;
    logic last_addr;
    logic out_free;
  } dp_status_t;

  // request action codes
  localparam logic ACT_CLASSIFY = 1'b0;
  localparam logic ACT_WRITE    = 1'b1;

  // bypass reason codes
  localparam logic [2:0] REASON_NONE     = 3'd0;
  localparam logic [2:0] REASON_LOOPBACK = 3'd1;
  localparam logic [2:0] REASON_MCAST    = 3'd2;
  localparam logic [2:0] REASON_LLOCAL   = 3'd3;
  localparam logic [2:0] REASON_ENDPOINT = 3'd4;
  localparam logic [2:0] REASON_PREFIX   = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_VALUE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_IS_V6  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_PORT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_HI     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_LO     = 3'd6;
  localparam int CFG_DATA_W = 64;

  // fixed address classes
  localparam logic [7:0]  V4_LOOPBACK_OCTET = 8'd127;
  localparam logic [3:0]  V4_MCAST_NIBBLE   = 4'd14;
  localparam logic [31:0] V4_BROADCAST      = 32'hffffffff;
  localparam logic [31:0] V6_LLOCAL_MASK    = 32'hffc00000;
  localparam logic [31:0] V6_LLOCAL_VALUE   = 32'hfe800000;
  localparam logic [31:0] V6_MCAST_MASK     = 32'hff000000;

endpackage

`default_nettype wire

@@ design/dbc_in_if.sv @@
// dbc_in_if: input request channel of the bypass classifier
// depends on dbc_pkg for the payload struct
`default_nettype none

interface dbc_in_if;
  logic              valid;
  logic              ready;
  dbc_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ design/dbc_out_if.sv @@
// dbc_out_if: result channel of the bypass classifier
// depends on dbc_pkg for the payload struct
`default_nettype none

interface dbc_out_if;
  logic               valid;
  logic               ready;
  dbc_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ design/dbc_ctrl.sv @@
// dbc_ctrl: sequencing state machine of the bypass classifier
// clearing pass, request decode, prefix scan and result hand-off; uses dbc_pkg
`default_nettype none

module dbc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dbc_pkg::dp_status_t status,
  output dbc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_DECODE   = 6'b000100,
    ST_SCAN     = 6'b001000,
    ST_SCAN_END = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.last_addr) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.item_is_write) begin
          cmd.mem_write = 1'b1;
          state_nxt     = ST_FINISH;
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.last_addr) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        // last compare lands in the hit flag here
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.push_result = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_result |-> status.out_free)
    else $error("result pushed while output register occupied");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && status.last_addr |=> state_r == ST_SCAN_END)
    else $error("scan did not stop after last table entry");

  a_write_only_for_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_write |-> status.item_is_write)
    else $error("table write issued for a classify request");

endmodule

`default_nettype wire

@@ design/dbc_datapath.sv @@
// dbc_datapath: registers, prefix table memory, address checks and result register
// driven by dbc_ctrl commands; uses dbc_pkg
`default_nettype none

module dbc_datapath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  dbc_pkg::ctrl_cmd_t                  cmd,
  output dbc_pkg::dp_status_t                 status,
  input  dbc_pkg::in_item_t                   in_item,
  input  wire                                 out_ready,
  output logic                                out_valid,
  output dbc_pkg::out_item_t                  out_item,
  input  wire                                 cfg_we,
  input  wire [dbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [dbc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // configuration registers
  logic        mark_en_r;
  logic [31:0] mark_value_r;
  logic        ep_en_r;
  logic        ep_v6_r;
  logic [15:0] ep_port_r;
  logic [63:0] ep_hi_r;
  logic [63:0] ep_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_en_r    <= 1'b0;
      mark_value_r <= '0;
      ep_en_r      <= 1'b0;
      ep_v6_r      <= 1'b0;
      ep_port_r    <= '0;
      ep_hi_r      <= '0;
      ep_lo_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dbc_pkg::CFG_MARK_ENABLE:     mark_en_r    <= cfg_wdata[0];
        dbc_pkg::CFG_MARK_VALUE:      mark_value_r <= cfg_wdata[31:0];
        dbc_pkg::CFG_ENDPOINT_ENABLE: ep_en_r      <= cfg_wdata[0];
        dbc_pkg::CFG_ENDPOINT_IS_V6:  ep_v6_r      <= cfg_wdata[0];
        dbc_pkg::CFG_ENDPOINT_PORT:   ep_port_r    <= cfg_wdata[15:0];
        dbc_pkg::CFG_ENDPOINT_HI:     ep_hi_r      <= cfg_wdata;
        dbc_pkg::CFG_ENDPOINT_LO:     ep_lo_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // request register
  dbc_pkg::in_item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_item;
  end

  // fixed address classes and endpoint match
  logic [31:0] v4_addr;
  logic [31:0] v6_w0;
  logic        ep_hit;
  logic        port_ok;
  logic [2:0]  fixed_reason;

  always_comb begin
    v4_addr      = item_r.addr_lo[31:0];
    v6_w0        = item_r.addr_hi[63:32];
    port_ok      = (ep_port_r == '0) || (item_r.dest_port == ep_port_r);
    fixed_reason = dbc_pkg::REASON_NONE;
    if (!item_r.is_v6) begin
      ep_hit = ep_en_r && !ep_v6_r && (v4_addr == ep_lo_r[31:0]);
      if (v4_addr[31:24] == dbc_pkg::V4_LOOPBACK_OCTET) begin
        fixed_reason = dbc_pkg::REASON_LOOPBACK;
      end else if ((v4_addr[31:28] == dbc_pkg::V4_MCAST_NIBBLE) ||
                   (v4_addr == dbc_pkg::V4_BROADCAST)) begin
        fixed_reason = dbc_pkg::REASON_MCAST;
      end else if (ep_hit && port_ok) begin
        fixed_reason = dbc_pkg::REASON_ENDPOINT;
      end
    end else begin
      ep_hit = ep_en_r && ep_v6_r && (item_r.addr_hi == ep_hi_r) &&
               (item_r.addr_lo == ep_lo_r);
      if ((item_r.addr_hi == '0) && (item_r.addr_lo == 64'd1)) begin
        fixed_reason = dbc_pkg::REASON_LOOPBACK;
      end else if ((v6_w0 & dbc_pkg::V6_LLOCAL_MASK) == dbc_pkg::V6_LLOCAL_VALUE) begin
        fixed_reason = dbc_pkg::REASON_LLOCAL;
      end else if ((v6_w0 & dbc_pkg::V6_MCAST_MASK) == dbc_pkg::V6_MCAST_MASK) begin
        fixed_reason = dbc_pkg::REASON_MCAST;
      end else if (ep_hit && port_ok) begin
        fixed_reason = dbc_pkg::REASON_ENDPOINT;
      end
    end
  end

  logic [2:0] fixed_reason_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) fixed_reason_r <= fixed_reason;
  end

  // table address counter, shared by the clearing pass and the scan
  logic [IDX_W-1:0] rd_addr_r, rd_addr_nxt;
  logic             cmp_vld_r;

  always_comb begin
    rd_addr_nxt = rd_addr_r;
    if (cmd.clr_step || cmd.scan_step) begin
      rd_addr_nxt = (rd_addr_r == LAST_IDX) ? '0 : rd_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      rd_addr_r <= rd_addr_nxt;
      cmp_vld_r <= cmd.scan_step;
    end
  end

  // prefix table memory, one write and one registered read port
  dbc_pkg::entry_t  mem_r [TABLE_ENTRIES];
  dbc_pkg::entry_t  rd_data_r;
  dbc_pkg::entry_t  mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic             idx_ok;
  logic             mem_we;

  always_comb begin
    idx_ok    = 32'(item_r.entry_index) < TABLE_ENTRIES;
    mem_we    = cmd.clr_step || (cmd.mem_write && idx_ok);
    mem_waddr = cmd.clr_step ? rd_addr_r : IDX_W'(item_r.entry_index);
    mem_wdata = '0;
    if (!cmd.clr_step) begin
      mem_wdata.valid = item_r.entry_valid;
      mem_wdata.is_v6 = item_r.is_v6;
      mem_wdata.len   = item_r.entry_length;
      mem_wdata.bits  = item_r.is_v6 ? {item_r.addr_hi, item_r.addr_lo}
                                     : {96'd0, item_r.addr_lo[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
    if (cmd.scan_step) rd_data_r <= mem_r[rd_addr_r];
  end

  // prefix compare against the row read last cycle
  logic [127:0] diff;
  logic [127:0] mask128;
  logic [31:0]  mask32;
  logic         covers;

  always_comb begin
    diff    = {item_r.addr_hi, item_r.addr_lo} ^ rd_data_r.bits;
    // lengths past the family width shift everything out, i.e. a full mask
    mask128 = ~({128{1'b1}} >> rd_data_r.len);
    mask32  = ~({32{1'b1}} >> rd_data_r.len);
    covers  = rd_data_r.valid && (rd_data_r.is_v6 == item_r.is_v6) &&
              (rd_data_r.is_v6 ? ((diff & mask128) == '0)
                               : ((diff[31:0] & mask32) == '0));
  end

  logic hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.eval) begin
      hit_r <= 1'b0;
    end else if (cmp_vld_r && covers) begin
      hit_r <= 1'b1;
    end
  end

  // result assembly
  dbc_pkg::out_item_t result;

  always_comb begin
    result = '0;
    if (item_r.action == dbc_pkg::ACT_CLASSIFY) begin
      if (fixed_reason_r != dbc_pkg::REASON_NONE) begin
        result.reason = fixed_reason_r;
      end else if (hit_r) begin
        result.reason = dbc_pkg::REASON_PREFIX;
      end
      result.bypass = (result.reason != dbc_pkg::REASON_NONE);
      if (!result.bypass && mark_en_r) begin
        result.set_mark = 1'b1;
        result.mark_out = mark_value_r;
      end
    end
  end

  // output register
  logic               out_valid_r;
  dbc_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_result) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign status.item_is_write = (item_r.action == dbc_pkg::ACT_WRITE);
  assign status.last_addr     = (rd_addr_r == LAST_IDX);
  assign status.out_free      = !out_valid_r || out_ready;

  // checks
  a_bypass_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.bypass == (out_item_r.reason != dbc_pkg::REASON_NONE)))
    else $error("bypass flag disagrees with reason");

  a_mark_not_on_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.set_mark |-> !out_item_r.bypass && mark_en_r)
    else $error("mark requested for bypassed or unmarked traffic");

  a_mark_zero_when_unset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.set_mark |-> out_item_r.mark_out == '0)
    else $error("mark value present without set_mark");

endmodule

`default_nettype wire

@@ design/destination_bypass_classifier.sv @@
// Destination bypass classifier. After reset the prefix table memory is cleared
// one row per cycle, during which no request is taken (configuration writes
// are). A table-write request goes from decode straight to the finish state
// and gives an all-zero result. A classify request also scans the prefix
// table, which sits in a single-read-port memory, one row per cycle, with the
// fixed class and endpoint checks done in the decode state before the scan.
// One request is in flight at a time; a finished result waits in an output
// register while the next request is taken.
// Depends on dbc_pkg, dbc_in_if, dbc_out_if, dbc_ctrl and dbc_datapath.
`default_nettype none

module destination_bypass_classifier #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  dbc_in_if.sink                           in_chan,
  dbc_out_if.source                        out_chan,
  input  wire                              cfg_we,
  input  wire [dbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [dbc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  dbc_pkg::ctrl_cmd_t  cmd;
  dbc_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;
  dbc_pkg::out_item_t  out_item;

  // sequencing
  dbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and compare
  dbc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_chan.item),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.item  = out_item;

endmodule

`default_nettype wire
